// ----- design/skt_pkg.sv -----
// skt_pkg: types and codes shared by the sorted key table cells and top level.
// No dependencies.
`timescale 1ns / 1ps

package skt_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // id reported when a find misses or for non-find commands
  localparam logic [7:0] ID_NONE = 8'hFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key;
    logic [7:0] section;
    logic [7:0] option;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [7:0] found_section;
    logic [7:0] found_option;
  } out_item_t;

  // contents of one cell
  typedef struct packed {
    logic       occ;
    logic [7:0] key;
    logic [7:0] section;
    logic [7:0] option;
  } skt_entry_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic       capture;    // register compare flags
    logic       is_remove;  // flag hit on section instead of key
    logic       apply_ins;  // open a slot and place the new entry
    logic       shift;      // close the lowest hole
    logic [7:0] key;
    logic [7:0] section;
    logic [7:0] option;
  } skt_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } skt_state_t;

endpackage

// ----- design/skt_cell.sv -----
// skt_cell: one slot of the sorted table, with compare flags and neighbor moves.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  skt_pkg::skt_ctrl_t  ctrl,
  input  skt_pkg::skt_entry_t left_entry,
  input  logic                left_lt,
  input  logic                left_shift,
  input  skt_pkg::skt_entry_t right_entry,
  input  logic                right_hit,
  output skt_pkg::skt_entry_t entry,
  output logic                lt,
  output logic                hit,
  output logic                shift_o
);
  import skt_pkg::*;

  logic       occ_r;
  logic [7:0] key_r;
  logic [7:0] section_r;
  logic [7:0] option_r;
  logic       lt_r;
  logic       hit_r;
  logic       lt_cmp;
  logic       hit_cmp;
  logic       shift_here;
  logic       take_new;

  // compare against the broadcast key / section
  always_comb begin
    lt_cmp  = occ_r && (key_r < ctrl.key);
    hit_cmp = occ_r && (ctrl.is_remove ? (section_r == ctrl.section) : (key_r == ctrl.key));
  end

  // a cell shifts down when it or any lower cell is a hole
  assign shift_here = left_shift | hit_r;
  assign take_new   = !lt_r && left_lt;

  // control flags and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      lt_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      priority if (ctrl.capture) begin
        lt_r  <= lt_cmp;
        hit_r <= hit_cmp;
      end else if (ctrl.apply_ins) begin
        if (!lt_r) begin
          occ_r <= take_new ? 1'b1 : left_entry.occ;
        end
      end else if (ctrl.shift && shift_here) begin
        occ_r <= right_entry.occ;
        hit_r <= right_hit;
      end else begin
        // no move this cycle
        occ_r <= occ_r;
      end
    end
  end

  // payload moves with occupancy
  always_ff @(posedge clk) begin
    if (!ctrl.capture && ctrl.apply_ins && !lt_r) begin
      key_r     <= take_new ? ctrl.key     : left_entry.key;
      section_r <= take_new ? ctrl.section : left_entry.section;
      option_r  <= take_new ? ctrl.option  : left_entry.option;
    end else if (!ctrl.capture && !ctrl.apply_ins && ctrl.shift && shift_here) begin
      key_r     <= right_entry.key;
      section_r <= right_entry.section;
      option_r  <= right_entry.option;
    end
  end

  assign entry   = '{occ: occ_r, key: key_r, section: section_r, option: option_r};
  assign lt      = lt_r;
  assign hit     = hit_r;
  assign shift_o = shift_here;

endmodule

// ----- design/sorted_key_table_unit.sv -----
// sorted_key_table_unit: sorted key table built as a chain of skt_cell slots.
// Depends on skt_pkg and skt_cell.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | skt_pkg::in_item_t  (cmd, key, section, option)
//  out_    | output    | out_valid/out_stall | skt_pkg::out_item_t (status, found, ids)
//
// Insert and find first register every cell's compare flags, then decide and
// move the chain. A remove also closes one hole per cycle until no cell hits.
// Reset (rst_n low, synchronous) empties the table and the output register.
// A stalled result holds the sequencer in its decide cycle: an insert does
// not move the chain until the result drains, while a remove compacts first
// and then waits.
`timescale 1ns / 1ps

module sorted_key_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skt_pkg::out_item_t  out_data
);
  import skt_pkg::*;

  skt_state_t  state_r;
  skt_state_t  state_nxt;
  in_item_t    item_r;
  out_item_t   out_r;
  out_item_t   result;
  logic        out_valid_r;
  logic        accept;
  logic        out_free;
  logic        done;
  logic        any_hit;
  logic        full;
  logic [7:0]  hit_section;
  logic [7:0]  hit_option;
  skt_ctrl_t   ctrl;

  skt_entry_t  entries [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] shift_vec;
  logic [CAPACITY-1:0] occ_vec;

  // cell chain; boundaries: below cell 0 acts as "less than", above the top is empty
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skt_entry_t left_e;
    skt_entry_t right_e;
    logic       left_l;
    logic       left_s;
    logic       right_h;

    if (i == 0) begin : g_lo
      assign left_e = '0;
      assign left_l = 1'b1;
      assign left_s = 1'b0;
    end else begin : g_mid_lo
      assign left_e = entries[i-1];
      assign left_l = lt_vec[i-1];
      assign left_s = shift_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi
      assign right_e = '0;
      assign right_h = 1'b0;
    end else begin : g_mid_hi
      assign right_e = entries[i+1];
      assign right_h = hit_vec[i+1];
    end

    skt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_entry (left_e),
      .left_lt    (left_l),
      .left_shift (left_s),
      .right_entry(right_e),
      .right_hit  (right_h),
      .entry      (entries[i]),
      .lt         (lt_vec[i]),
      .hit        (hit_vec[i]),
      .shift_o    (shift_vec[i])
    );

    assign occ_vec[i] = entries[i].occ;
  end

  assign any_hit = |hit_vec;
  assign full    = occ_vec[CAPACITY-1];

  // one-hot select of the matching entry (keys are unique)
  always_comb begin
    hit_section = '0;
    hit_option  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_section = hit_section | (entries[i].section & {8{hit_vec[i]}});
      hit_option  = hit_option  | (entries[i].option  & {8{hit_vec[i]}});
    end
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (done)     state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl           = '0;
    done           = 1'b0;
    in_stall       = 1'b1;
    ctrl.is_remove = (state_r == ST_IDLE) ? (in_data.cmd == CMD_REMOVE)
                                          : (item_r.cmd == CMD_REMOVE);
    ctrl.key       = (state_r == ST_IDLE) ? in_data.key     : item_r.key;
    ctrl.section   = (state_r == ST_IDLE) ? in_data.section : item_r.section;
    ctrl.option    = (state_r == ST_IDLE) ? in_data.option  : item_r.option;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        ctrl.capture = in_valid;
      end
      ST_EXEC: begin
        if (item_r.cmd == CMD_INSERT) begin
          done           = out_free;
          ctrl.apply_ins = out_free && !any_hit && !full;
        end else if (item_r.cmd == CMD_REMOVE) begin
          ctrl.shift = any_hit;
          done       = !any_hit && out_free;
        end else begin
          done = out_free;
        end
      end
      default: ;
    endcase
  end

  // result of the command held in item_r
  always_comb begin
    result.status        = STATUS_OK;
    result.found         = 1'b0;
    result.found_section = ID_NONE;
    result.found_option  = ID_NONE;
    if (item_r.cmd == CMD_INSERT) begin
      if (any_hit) begin
        result.status = STATUS_DUP;
      end else if (full) begin
        result.status = STATUS_FULL;
      end
    end else if (item_r.cmd == CMD_FIND && any_hit) begin
      result.found         = 1'b1;
      result.found_section = hit_section;
      result.found_option  = hit_option;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC && done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == ST_EXEC && done) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // occupied cells always form a block starting at cell 0
  a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("occupied cells not contiguous");

  // a placed insert grows the table by exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.apply_ins |=> $countones(occ_vec) == $past($countones(occ_vec)) + 1)
    else $error("insert did not add one entry");

  // each compaction step drops exactly one entry
  a_shift_drops: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |=> $countones(occ_vec) + 1 == $past($countones(occ_vec)))
    else $error("compaction step did not remove one entry");
`endif

endmodule

// ----- tb/sv/sorted_key_table_unit_tb.sv -----
// sorted_key_table_unit_tb: self-checking bench for the sorted key table unit.
// Depends on skt_pkg and sorted_key_table_unit; a shadow table predicts every reply.
`timescale 1ns / 1ps

module sorted_key_table_unit_tb;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MIXED_PER_PHASE = 280;

  // command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Shadow copy of the table plus the replies still owed by the block
  class skt_shadow_table;
    logic [7:0] keys [TABLE_DEPTH];
    logic [7:0] sections [TABLE_DEPTH];
    logic [7:0] options [TABLE_DEPTH];
    int unsigned count;
    out_item_t replies_due [$];
    int unsigned errors;
    int unsigned n_ins, n_dup, n_full, n_rem, n_find, n_hit, n_unused;

    function new();
      count = 0;
      errors = 0;
      n_ins = 0; n_dup = 0; n_full = 0; n_rem = 0;
      n_find = 0; n_hit = 0; n_unused = 0;
    endfunction

    function bit holds_key(logic [7:0] k);
      for (int i = 0; i < count; i++) if (keys[i] == k) return 1'b1;
      return 1'b0;
    endfunction

    // Apply one accepted transaction to the shadow table, queue its reply
    function void note_accepted(in_item_t it);
      out_item_t rsp;
      int unsigned pos;
      int unsigned wr;
      rsp.status = STATUS_OK;
      rsp.found = 1'b0;
      rsp.found_section = ID_NONE;
      rsp.found_option = ID_NONE;
      case (it.cmd)
        CMD_INSERT: begin
          n_ins++;
          pos = 0;
          while (pos < count && keys[pos] < it.key) pos++;
          if (pos < count && keys[pos] == it.key) begin
            rsp.status = STATUS_DUP;
            n_dup++;
          end else if (count >= TABLE_DEPTH) begin
            rsp.status = STATUS_FULL;
            n_full++;
          end else begin
            for (int j = count; j > pos; j--) begin
              keys[j] = keys[j-1];
              sections[j] = sections[j-1];
              options[j] = options[j-1];
            end
            keys[pos] = it.key;
            sections[pos] = it.section;
            options[pos] = it.option;
            count++;
          end
        end
        CMD_REMOVE: begin
          n_rem++;
          wr = 0;
          for (int rd = 0; rd < count; rd++) begin
            if (sections[rd] != it.section) begin
              keys[wr] = keys[rd];
              sections[wr] = sections[rd];
              options[wr] = options[rd];
              wr++;
            end
          end
          count = wr;
        end
        CMD_FIND: begin
          n_find++;
          for (int i = 0; i < count; i++) begin
            if (keys[i] == it.key) begin
              rsp.found = 1'b1;
              rsp.found_section = sections[i];
              rsp.found_option = options[i];
              n_hit++;
              break;
            end
          end
        end
        default: n_unused++;  // unused code: no state change
      endcase
      replies_due.push_back(rsp);
    endfunction

    // Compare a reply against the oldest one owed
    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("reply with none outstanding: status %0d found %0d ids %0d/%0d",
               got.status, got.found, got.found_section, got.found_option);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found mismatch: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.found_section !== want.found_section) begin
        $error("found_section mismatch: expected %0d, got %0d",
               want.found_section, got.found_section);
        errors++;
      end
      if (got.found_option !== want.found_option) begin
        $error("found_option mismatch: expected %0d, got %0d",
               want.found_option, got.found_option);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  skt_shadow_table shadow = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;

  sorted_key_table_unit #(.CAPACITY(TABLE_DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_key_table_unit_tb: done, errors");
      $finish;
    end
  end

  // Reply side: check accepted transactions, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shadow.check_reply(out_data);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Drive one command; valid stays high afterwards unless the next call idles
  task automatic send_item(input in_item_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_accepted(item);
    items_sent++;
  endtask

  function automatic in_item_t make_item(logic [1:0] c, logic [7:0] k,
                                         logic [7:0] s, logic [7:0] o);
    in_item_t it;
    it.cmd = c;
    it.key = k;
    it.section = s;
    it.option = o;
    return it;
  endfunction

  // Sections mostly from a small pool so removes hit several entries
  function automatic logic [7:0] pick_section();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] stored_key();
    return shadow.keys[$urandom_range(0, shadow.count - 1)];
  endfunction

  function automatic logic [7:0] absent_key();
    logic [7:0] k;
    do k = 8'($urandom_range(0, 255)); while (shadow.holds_key(k));
    return k;
  endfunction

  function automatic in_item_t random_item();
    int unsigned r;
    logic [7:0] k;
    r = $urandom_range(0, 99);
    k = 8'($urandom_range(0, 255));
    if (shadow.count > 0 && $urandom_range(0, 99) < 40) k = stored_key();
    if (r < 45)
      return make_item(CMD_INSERT, k, pick_section(), 8'($urandom_range(0, 255)));
    if (r < 80)
      return make_item(CMD_FIND, k, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    if (r < 95)
      return make_item(CMD_REMOVE, 8'($urandom_range(0, 255)), pick_section(),
                       8'($urandom_range(0, 255)));
    return make_item(CMD_UNUSED, k, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
  endfunction

  // Fill the table to capacity, then push on it while full
  task automatic fill_table();
    while (shadow.count < TABLE_DEPTH)
      send_item(make_item(CMD_INSERT, 8'($urandom_range(0, 255)), pick_section(),
                          8'($urandom_range(0, 255))));
    send_item(make_item(CMD_INSERT, stored_key(), pick_section(), 8'hA5));
    send_item(make_item(CMD_INSERT, absent_key(), pick_section(), 8'h5A));
    send_item(make_item(CMD_FIND, stored_key(), 8'h00, 8'h00));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct = 75;

    // Directed: empty table, extremes, duplicates, removes, unused code
    send_item(make_item(CMD_FIND,   8'd0,   8'd0,   8'd0));
    send_item(make_item(CMD_REMOVE, 8'd0,   8'd0,   8'd0));
    send_item(make_item(CMD_UNUSED, 8'hFF,  8'hFF,  8'hFF));
    send_item(make_item(CMD_INSERT, 8'd128, 8'd0,   8'd0));
    send_item(make_item(CMD_INSERT, 8'd0,   8'hFF,  8'hFF));
    send_item(make_item(CMD_INSERT, 8'hFF,  8'd254, 8'd254));
    send_item(make_item(CMD_INSERT, 8'd64,  8'd1,   8'hAA));
    send_item(make_item(CMD_INSERT, 8'd128, 8'd3,   8'd3));
    send_item(make_item(CMD_FIND,   8'd0,   8'd0,   8'd0));
    send_item(make_item(CMD_FIND,   8'hFF,  8'd0,   8'd0));
    send_item(make_item(CMD_FIND,   8'd128, 8'd0,   8'd0));
    send_item(make_item(CMD_FIND,   8'd1,   8'd0,   8'd0));
    send_item(make_item(CMD_INSERT, 8'd200, 8'd1,   8'h55));
    send_item(make_item(CMD_FIND,   8'd64,  8'd0,   8'd0));
    send_item(make_item(CMD_REMOVE, 8'd0,   8'd1,   8'd0));
    send_item(make_item(CMD_FIND,   8'd64,  8'd0,   8'd0));
    send_item(make_item(CMD_REMOVE, 8'd0,   8'd7,   8'd0));
    send_item(make_item(CMD_FIND,   8'd200, 8'd0,   8'd0));
    send_item(make_item(CMD_UNUSED, 8'd0,   8'd0,   8'd0));
    send_item(make_item(CMD_REMOVE, 8'hFF,  8'hFF,  8'hFF));
    send_item(make_item(CMD_FIND,   8'd0,   8'd0,   8'd0));
    send_item(make_item(CMD_INSERT, 8'h55,  8'h55,  8'h55));
    send_item(make_item(CMD_FIND,   8'h55,  8'd0,   8'd0));

    // Random: three idling profiles, each starting with a fill to capacity
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 38; recv_idle_pct = 75; end
        1: begin send_idle_pct = 75; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      fill_table();
      for (int n = 0; n < MIXED_PER_PHASE; n++) send_item(random_item());
    end
    in_valid <= 1'b0;
    recv_idle_pct = 0;

    while (shadow.replies_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions: %0d inserts (%0d duplicate, %0d full), %0d removes",
             items_sent, shadow.n_ins, shadow.n_dup, shadow.n_full, shadow.n_rem);
    $display("%0d finds (%0d hits), %0d unused codes, %0d cycles",
             shadow.n_find, shadow.n_hit, shadow.n_unused, cycle_count);
    if (shadow.errors == 0 && shadow.replies_due.size() == 0)
      $display("sorted_key_table_unit_tb: done, clean");
    else
      $display("sorted_key_table_unit_tb: done, errors");
    $finish;
  end

endmodule
